/* design/anagram_window_finder_macros.svh */
// Assertion helpers shared by the anagram window finder RTL.
// All checks sample on clk and are held off while rst_n is low.
`ifndef ANAGRAM_WINDOW_FINDER_MACROS_SVH
`define ANAGRAM_WINDOW_FINDER_MACROS_SVH

// Same-cycle implication.
`define AWF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define AWF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must never be seen.
`define AWF_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

/* design/awf_pkg.sv */
`timescale 1ns / 1ps

package awf_pkg;

    // Sizing
    localparam int MAX_PATTERN = 64;
    localparam int ALPHABET    = 26;
    localparam int RING_DEPTH  = MAX_PATTERN + 1;

    // Fixed field widths
    localparam int ACTION_W = 2;
    localparam int LETTER_W = 5;
    localparam int POS_W    = 32;

    // Derived widths
    localparam int CNT_W      = $clog2(MAX_PATTERN + 2);
    localparam int BAL_W      = $clog2(MAX_PATTERN + 2) + 1;
    localparam int BAL_AW     = $clog2(ALPHABET);
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int RING_SUM_W = $clog2(2 * RING_DEPTH);

    // Result queue
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

endpackage

/* design/awf_if.sv */
`timescale 1ns / 1ps

// Input channel: one letter word per handshake
interface awf_letter_if;
    logic                          valid;
    logic                          ready;
    logic [awf_pkg::ACTION_W-1:0]  action;
    logic [awf_pkg::LETTER_W-1:0]  letter;

    modport source (output valid, output action, output letter, input ready);
    modport sink   (input valid, input action, input letter, output ready);
endinterface

// Output channel: one match word per handshake
interface awf_match_if;
    logic                       valid;
    logic                       ready;
    logic [awf_pkg::POS_W-1:0]  window_start;

    modport source (output valid, output window_start, input ready);
    modport sink   (input valid, input window_start, output ready);
endinterface

/* design/awf_result_fifo.sv */
`timescale 1ns / 1ps
`include "anagram_window_finder_macros.svh"

module awf_result_fifo (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic [awf_pkg::POS_W-1:0]     push_data,
    output logic [awf_pkg::FIFO_CW-1:0]   level,
    awf_match_if.source                   found
);
    import awf_pkg::*;

    logic [POS_W-1:0]   data_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg;
    logic [FIFO_CW-1:0] count_next;
    logic               pop;

    assign pop                = found.valid && found.ready;
    assign found.valid        = (count_reg != '0);
    assign found.window_start = data_reg[rd_ptr_reg];
    assign level              = count_reg;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + FIFO_CW'(push) - FIFO_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    `AWF_ASSERT_NEVER(a_no_overflow, push && !pop && (count_reg == FIFO_CW'(FIFO_DEPTH)),
                      "result queue overflow")
    `AWF_ASSERT_NEVER(a_count_range, count_reg > FIFO_CW'(FIFO_DEPTH),
                      "result queue count out of range")
    `AWF_ASSERT_NEXT(a_push_shows, push && (count_reg == '0), found.valid,
                     "pushed word not offered")

endmodule

/* design/anagram_window_finder.sv */
`timescale 1ns / 1ps
`include "anagram_window_finder_macros.svh"

// Anagram window finder.
// letters: each word carries an action (pattern letter, text letter, clear) and a
// letter index. Pattern letters build the per-letter balance table until the first
// text letter; text letters slide a window of pattern length over the text.
// found: one word per matching window, giving the position of its first letter.
// Throughput: a pattern or text letter holds ready low while it is in stage 1, so
// a new letter is taken only once that stage is free; clear, unused actions and
// ignored words are taken every cycle while stage 1 is free and the queue has room.
// The limit is set by the balance memory, which has one read and one write port:
// a text letter reads and writes the entering letter's entry, then the leaving
// letter's entry, one per cycle; a match word is pushed from the leave stage.
// Results go into a 2-word queue; when the receiver stalls the queue fills and
// ready drops as soon as a further result could not be stored.
// Reset (rst_n low, asynchronous) and a clear word empty all counters and mark every
// balance entry as zero through per-entry valid bits; there is no clearing pass.
// The window ring memory is not cleared; only entries written since are read.
module anagram_window_finder (
    input  logic      clk,
    input  logic      rst_n,
    awf_letter_if.sink   letters,
    awf_match_if.source  found
);
    import awf_pkg::*;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PATTERN = 2'd0,
        ACT_TEXT    = 2'd1,
        ACT_CLEAR   = 2'd2
    } action_t;

    typedef logic [BAL_AW-1:0]  sym_t;
    typedef logic [BAL_W-1:0]   bal_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [RING_AW-1:0] ring_ptr_t;
    typedef logic [POS_W-1:0]   pos_t;

    // Enter stage: balance of the entering letter arrives
    typedef struct packed {
        logic text;
        logic leave;
        logic ring_same;
        sym_t addr;
        pos_t start;
    } stage1_t;

    // Leave stage: balance of the leaving letter arrives
    typedef struct packed {
        logic leave;
        sym_t addr;
        pos_t start;
    } stage2_t;

    // Architectural counters
    cnt_t      plen_reg,     plen_next;
    cnt_t      hit_count_reg, hit_count_next;
    cnt_t      fill_reg,     fill_next;
    pos_t      text_pos_reg, text_pos_next;
    logic      started_reg,  started_next;
    ring_ptr_t ring_wr_reg,  ring_wr_next;

    // Pipeline
    logic    s1_valid_reg;
    stage1_t s1_reg;
    logic    s2_valid_reg;
    stage2_t s2_reg;

    // Memories
    bal_t              bal_mem  [ALPHABET];
    sym_t              ring_mem [RING_DEPTH];
    logic [ALPHABET-1:0] bal_vld_reg;
    bal_t              bal_rd_reg;
    logic              bal_rd_vld_reg;
    sym_t              ring_rd_reg;

    // Write forwarding: the write committed at the last edge
    logic fwd_vld_reg;
    sym_t fwd_addr_reg;
    bal_t fwd_data_reg;

    // Input decode
    logic      accept;
    logic      sym_ok;
    sym_t      sym_addr;
    logic      clear_acc;
    logic      text_acc;
    logic      pat_acc;
    cnt_t      fill_inc;
    logic      leave;
    cnt_t      fill_after;
    logic [RING_SUM_W-1:0] lv_sum;
    ring_ptr_t lv_idx;
    pos_t      start_pos;

    // Balance port
    logic bal_wr_en;
    sym_t bal_wr_addr;
    bal_t bal_wr_data;
    sym_t bal_rd_addr;

    // Stage arithmetic
    bal_t bal1;
    bal_t bal2;
    logic enter_hit;
    sym_t old_addr;
    logic leave_dec;
    cnt_t hit_final;
    logic push;

    logic [FIFO_CW-1:0] fifo_level;

    assign accept    = letters.valid && letters.ready;
    assign sym_ok    = 32'(letters.letter) < ALPHABET;
    assign sym_addr  = sym_ok ? BAL_AW'(letters.letter) : '0;
    assign clear_acc = accept && (letters.action == ACT_CLEAR);
    assign text_acc  = accept && (letters.action == ACT_TEXT) && sym_ok;
    assign pat_acc   = accept && (letters.action == ACT_PATTERN) && sym_ok
                       && !started_reg && (plen_reg < CNT_W'(MAX_PATTERN));

    // Window bookkeeping is known at accept time
    assign fill_inc   = fill_reg + 1'b1;
    assign leave      = fill_inc > plen_reg;
    assign fill_after = leave ? fill_reg : fill_inc;
    assign start_pos  = text_pos_reg + 1'b1 - POS_W'(fill_after);

    // Ring slot of the oldest letter (ring_wr - fill, modulo ring depth)
    always_comb
    begin
        lv_sum = RING_SUM_W'(ring_wr_reg) + RING_SUM_W'(RING_DEPTH) - RING_SUM_W'(fill_reg);
        if (lv_sum >= RING_SUM_W'(RING_DEPTH))
        begin
            lv_idx = RING_AW'(lv_sum - RING_SUM_W'(RING_DEPTH));
        end
        else
        begin
            lv_idx = RING_AW'(lv_sum);
        end
    end

    // Stage 1: entering letter (or pattern letter)
    always_comb
    begin
        if (fwd_vld_reg && (fwd_addr_reg == s1_reg.addr))
        begin
            bal1 = fwd_data_reg;
        end
        else
        begin
            bal1 = bal_rd_vld_reg ? bal_rd_reg : '0;
        end
        enter_hit = $signed(bal1) > 0;
        old_addr  = s1_reg.ring_same ? s1_reg.addr : ring_rd_reg;
    end

    // Stage 2: leaving letter and match check
    always_comb
    begin
        if (fwd_vld_reg && (fwd_addr_reg == s2_reg.addr))
        begin
            bal2 = fwd_data_reg;
        end
        else
        begin
            bal2 = bal_rd_vld_reg ? bal_rd_reg : '0;
        end
        leave_dec = s2_reg.leave && ($signed(bal2) >= 0) && (hit_count_reg != '0);
        hit_final = hit_count_reg - CNT_W'(leave_dec);
        push      = s2_valid_reg && (hit_final == plen_reg);
    end

    // Balance port: stages 1 and 2 never hold words at once
    always_comb
    begin
        bal_wr_en   = 1'b0;
        bal_wr_addr = s1_reg.addr;
        bal_wr_data = s1_reg.text ? bal1 - 1'b1 : bal1 + 1'b1;
        if (s1_valid_reg)
        begin
            bal_wr_en = 1'b1;
        end
        else if (s2_valid_reg && s2_reg.leave)
        begin
            bal_wr_en   = 1'b1;
            bal_wr_addr = s2_reg.addr;
            bal_wr_data = bal2 + 1'b1;
        end
        bal_rd_addr = s1_valid_reg ? old_addr : sym_addr;
    end

    // Counter next state
    always_comb
    begin
        plen_next      = plen_reg;
        hit_count_next = hit_count_reg;
        fill_next      = fill_reg;
        text_pos_next  = text_pos_reg;
        started_next   = started_reg;
        ring_wr_next   = ring_wr_reg;
        if (clear_acc)
        begin
            plen_next      = '0;
            hit_count_next = '0;
            fill_next      = '0;
            text_pos_next  = '0;
            started_next   = 1'b0;
            ring_wr_next   = '0;
        end
        else
        begin
            if (pat_acc)
            begin
                plen_next = plen_reg + 1'b1;
            end
            if (text_acc)
            begin
                started_next  = 1'b1;
                text_pos_next = text_pos_reg + 1'b1;
                fill_next     = fill_after;
                ring_wr_next  = (ring_wr_reg == RING_AW'(RING_DEPTH - 1)) ? '0
                                                                       : ring_wr_reg + 1'b1;
            end
            if (s1_valid_reg && s1_reg.text)
            begin
                hit_count_next = hit_count_reg + CNT_W'(enter_hit);
            end
            else if (s2_valid_reg)
            begin
                hit_count_next = hit_final;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg      <= '0;
            hit_count_reg <= '0;
            fill_reg      <= '0;
            text_pos_reg  <= '0;
            started_reg   <= 1'b0;
            ring_wr_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            fwd_vld_reg   <= 1'b0;
            bal_vld_reg   <= '0;
        end
        else
        begin
            plen_reg      <= plen_next;
            hit_count_reg <= hit_count_next;
            fill_reg      <= fill_next;
            text_pos_reg  <= text_pos_next;
            started_reg   <= started_next;
            ring_wr_reg   <= ring_wr_next;
            s1_valid_reg  <= text_acc || pat_acc;
            s2_valid_reg  <= s1_valid_reg && s1_reg.text;
            fwd_vld_reg   <= bal_wr_en && !clear_acc;
            if (clear_acc)
            begin
                bal_vld_reg <= '0;
            end
            else if (bal_wr_en)
            begin
                bal_vld_reg[bal_wr_addr] <= 1'b1;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.text      <= text_acc;
            s1_reg.leave     <= leave;
            s1_reg.ring_same <= (lv_idx == ring_wr_reg);
            s1_reg.addr      <= sym_addr;
            s1_reg.start     <= start_pos;
        end
        if (s1_valid_reg)
        begin
            s2_reg.leave <= s1_reg.leave;
            s2_reg.addr  <= old_addr;
            s2_reg.start <= s1_reg.start;
        end
        fwd_addr_reg <= bal_wr_addr;
        fwd_data_reg <= bal_wr_data;
    end

    // Balance memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (bal_wr_en)
        begin
            bal_mem[bal_wr_addr] <= bal_wr_data;
        end
        bal_rd_reg     <= bal_mem[bal_rd_addr];
        bal_rd_vld_reg <= bal_vld_reg[bal_rd_addr];
    end

    // Window ring memory: store entering letter, fetch oldest letter
    always_ff @(posedge clk)
    begin
        if (text_acc)
        begin
            ring_mem[ring_wr_reg] <= sym_addr;
            ring_rd_reg           <= ring_mem[lv_idx];
        end
    end

    // Take a word only with stage 1 free and a queue slot reserved for its result
    assign letters.ready = !s1_valid_reg
                           && ((FIFO_CW + 1)'(fifo_level) + (FIFO_CW + 1)'(s2_valid_reg)
                               < (FIFO_CW + 1)'(FIFO_DEPTH));

    awf_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (s2_reg.start),
        .level     (fifo_level),
        .found     (found)
    );

    `AWF_ASSERT_NEVER(a_stage_excl, s1_valid_reg && s2_valid_reg,
                      "enter and leave stages overlap")
    `AWF_ASSERT_NEXT(a_text_enters, text_acc, s1_valid_reg && s1_reg.text,
                     "text word lost before enter stage")
    `AWF_ASSERT_NEVER(a_fill_bound, fill_reg > plen_reg, "window longer than pattern")
    `AWF_ASSERT_NEVER(a_hit_bound, hit_count_reg > plen_reg, "hit count above pattern length")

endmodule
